// File: sv/pis_pkg.sv
// package for the point illuminance sum block
// shared widths, lamp entry type, function codes and constants; no dependencies
`default_nettype none
package pis_pkg;

  localparam int unsigned LAMP_SLOTS_DEF = 128;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned POWER_W        = 16;
  localparam int unsigned LUX_W          = 32;
  localparam int unsigned HEIGHT_W       = 12;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned FUNC_W         = 2;

  // divider operands: output << 40 over d2 * 4pi in q16
  localparam int unsigned NUM_W   = 56;
  localparam int unsigned DEN_W   = 54;
  localparam int unsigned D2_W    = 34;
  localparam int unsigned QUOT_W  = 38;
  localparam int unsigned FOUR_PI_Q16 = 823549;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd132;
  localparam logic [LUX_W-1:0]    THRESH_RST = 32'd65536;
  localparam logic [LUX_W-1:0]    LUX_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLE_HEIGHT   = 8'd0,
    REG_LOW_THRESHOLD = 8'd1
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [POWER_W-1:0]        power;
  } lamp_t;

endpackage
`default_nettype wire

// File: sv/pis_if.sv
// stream and configuration interfaces of the point illuminance sum block
// depends on pis_pkg
`default_nettype none
interface pis_in_if import pis_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic [POWER_W-1:0]         lamp_output;
  modport source (output valid, func, pos_x, pos_y, lamp_output, input ready);
  modport sink   (input valid, func, pos_x, pos_y, lamp_output, output ready);
endinterface

interface pis_out_if import pis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LUX_W-1:0] illuminance;
  logic             below_limit;
  logic [7:0]       map_char;
  modport source (output valid, illuminance, below_limit, map_char, input ready);
  modport sink   (input valid, illuminance, below_limit, map_char, output ready);
endinterface

interface pis_cfg_if import pis_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/pis_lamp_mem.sv
// lamp table memory, one write port and one registered read port
// depends on pis_pkg
`default_nettype none
module pis_lamp_mem import pis_pkg::*; #(
  parameter int unsigned SLOTS = LAMP_SLOTS_DEF,
  parameter int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire lamp_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output lamp_t              rdata_o
);

  lamp_t mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: sv/pis_div.sv
// restoring divider, one quotient bit per cycle
// depends on pis_pkg
`default_nettype none
module pis_div import pis_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUOT_W-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] nq_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial  = {rem_q, nq_q[NUM_W-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign quot_o = nq_q[QUOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CNT_W'(NUM_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      nq_q  <= {nq_q[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: sv/point_illuminance_sum_top.sv
// point illuminance sum: clear and load keep the input ready; a query walks the n
// loaded lamps one at a time, each lamp with nonzero output through the bit-serial
// divider and a lamp with zero output past it, and stops early once the sum saturates
// the input is not ready while a query runs; one result register decouples the output
// and a finished query waits only while the previous result is still held
// reset: empty lamp table, pole height 132, threshold 65536; table contents undefined
// depends on pis_pkg, pis_if, pis_lamp_mem, pis_div
`default_nettype none
module point_illuminance_sum_top import pis_pkg::*; #(
  parameter int unsigned LAMP_SLOTS = LAMP_SLOTS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pis_in_if.sink     in_if,
  pis_out_if.source  out_if,
  pis_cfg_if.sink    cfg_if
);

  localparam int unsigned AW = (LAMP_SLOTS > 1) ? $clog2(LAMP_SLOTS) : 1;
  localparam int unsigned CW = $clog2(LAMP_SLOTS + 1);
  localparam int unsigned MW = COORD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_H2, S_RD, S_DX, S_DY, S_DEN, S_DIV, S_ACC, S_DONE
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        cnt_q, idx_q;
  logic [HEIGHT_W-1:0]  pole_q;
  logic [LUX_W-1:0]     thresh_q;
  logic signed [COORD_W-1:0] px_q, py_q;
  logic [2*HEIGHT_W-1:0] h2_q;
  logic [D2_W-1:0]      d2_q;
  logic [POWER_W-1:0]   power_q;
  logic [QUOT_W:0]      total_q;
  logic                 div_start_q;
  logic                 out_valid_q;
  logic [LUX_W-1:0]     out_lux_q;
  logic                 out_below_q;
  logic [7:0]           out_char_q;

  logic                 in_acc, load_we;
  lamp_t                lamp_wr, lamp_rd;
  logic signed [MW-1:0] diff;
  logic [MW-1:0]        mag, mul_a;
  logic [2*MW-1:0]      prod;
  logic [DEN_W-1:0]     den;
  logic                 div_done;
  logic [QUOT_W-1:0]    quot;
  logic [QUOT_W:0]      sum;

  function automatic logic [7:0] map_glyph(input logic [LUX_W-1:0] lux);
    logic [15:0] whole;
    whole = lux[LUX_W-1:16];
    case (whole) inside
      16'd0:   map_glyph = "-";
      16'd2:   map_glyph = "2";
      16'd4:   map_glyph = "4";
      16'd6:   map_glyph = "6";
      16'd8:   map_glyph = "8";
      16'd1, 16'd3, 16'd5, 16'd7, 16'd9: map_glyph = " ";
      default: map_glyph = "+";
    endcase
  endfunction

  assign in_if.ready  = (state_q == S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign load_we      = in_acc && (func_e'(in_if.func) == FUNC_LOAD)
                        && (cnt_q < CW'(LAMP_SLOTS));
  assign lamp_wr      = '{x: in_if.pos_x, y: in_if.pos_y, power: in_if.lamp_output};

  // shared squarer: pole height, then |dx|, then |dy|
  always_comb begin
    diff = (state_q == S_DY)
         ? ($signed({py_q[COORD_W-1], py_q}) - $signed({lamp_rd.y[COORD_W-1], lamp_rd.y}))
         : ($signed({px_q[COORD_W-1], px_q}) - $signed({lamp_rd.x[COORD_W-1], lamp_rd.x}));
    mag   = diff[MW-1] ? MW'(-diff) : MW'(diff);
    mul_a = (state_q == S_H2) ? MW'(pole_q) : mag;
    prod  = mul_a * mul_a;
  end

  assign den = DEN_W'(d2_q) * DEN_W'(FOUR_PI_Q16);
  assign sum = total_q + (QUOT_W+1)'(quot);

  pis_lamp_mem #(.SLOTS(LAMP_SLOTS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (lamp_wr),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (lamp_rd)
  );

  pis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   ({power_q, 40'd0}),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pole_q      <= HEIGHT_RST;
      thresh_q    <= THRESH_RST;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= (state_q == S_DEN) && (d2_q != '0);
      if (out_valid_q && out_if.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_POLE_HEIGHT:   pole_q   <= cfg_if.data[HEIGHT_W-1:0];
          REG_LOW_THRESHOLD: thresh_q <= cfg_if.data[LUX_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (func_e'(in_if.func))
              FUNC_CLEAR: cnt_q <= '0;
              FUNC_LOAD: begin
                if (load_we) cnt_q <= cnt_q + CW'(1);
              end
              FUNC_QUERY: begin
                px_q    <= in_if.pos_x;
                py_q    <= in_if.pos_y;
                total_q <= '0;
                idx_q   <= '0;
                state_q <= S_H2;
              end
              default: ;
            endcase
          end
        end
        S_H2: begin
          h2_q    <= prod[2*HEIGHT_W-1:0];
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= (idx_q == cnt_q) ? S_DONE : S_DX;
        end
        S_DX: begin
          d2_q    <= D2_W'(h2_q) + D2_W'(prod);
          state_q <= S_DY;
        end
        S_DY: begin
          d2_q    <= d2_q + D2_W'(prod);
          power_q <= lamp_rd.power;
          if (lamp_rd.power == '0) begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_RD;
          end else begin
            state_q <= S_DEN;
          end
        end
        S_DEN: begin
          // lamp right at the query point with no pole height
          if (d2_q == '0) begin
            total_q <= (QUOT_W+1)'(LUX_MAX);
            state_q <= S_DONE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_ACC;
        end
        S_ACC: begin
          if (sum >= (QUOT_W+1)'(LUX_MAX)) begin
            total_q <= (QUOT_W+1)'(LUX_MAX);
            state_q <= S_DONE;
          end else begin
            total_q <= sum;
            idx_q   <= idx_q + CW'(1);
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_lux_q   <= total_q[LUX_W-1:0];
            out_below_q <= total_q[LUX_W-1:0] < thresh_q;
            out_char_q  <= map_glyph(total_q[LUX_W-1:0]);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.illuminance = out_lux_q;
  assign out_if.below_limit = out_below_q;
  assign out_if.map_char    = out_char_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LAMP_SLOTS))
    else $error("lamp count beyond table size");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (idx_q <= cnt_q))
    else $error("lamp walk past loaded count");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (d2_q != '0))
    else $error("divider started with zero distance");

  a_total_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (total_q <= (QUOT_W+1)'(LUX_MAX)))
    else $error("sum above saturation level");

endmodule
`default_nettype wire
